>>> rtl/core/dpf_pkg.sv
`default_nettype none
package dpf_pkg;

  localparam int NB_CNT  = 8;
  localparam int Q_W     = 32;
  localparam int GAP_W   = 16;
  localparam int CFG_A_W = 2;

  // neighbour order nw, n, ne, w, e, sw, s, se; set bits are diagonal
  localparam logic [NB_CNT-1:0] DIAG_MASK = 8'b1010_0101;

  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [CFG_A_W-1:0] REG_NODATA     = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_FILL_START = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_GAP_CARD   = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_GAP_DIAG   = 2'd3;

  localparam logic [Q_W-1:0]   NODATA_RST     = 32'hD8F1_0000;
  localparam logic [Q_W-1:0]   FILL_START_RST = 32'd655360000;
  localparam logic [GAP_W-1:0] GAP_CARD_RST   = 16'd33;
  localparam logic [GAP_W-1:0] GAP_DIAG_RST   = 16'd46;
  localparam logic [Q_W-1:0]   Q_MAX          = 32'h7FFF_FFFF;

  typedef logic signed [Q_W-1:0] q16_t;

  typedef struct packed {
    q16_t             nodata;
    q16_t             fill_start;
    logic [GAP_W-1:0] gap_card;
    logic [GAP_W-1:0] gap_diag;
  } cfg_t;

  typedef struct packed {
    logic              init;
    q16_t              init_val;
    logic              keep;
    logic              nb_nodata;
    q16_t              elev;
    q16_t              fill;
    q16_t [NB_CNT-1:0] sum;
  } s1_t;

  typedef struct packed {
    logic                init;
    q16_t                init_val;
    logic                keep;
    logic                drop;
    q16_t                elev;
    q16_t                fill;
    q16_t [NB_CNT/2-1:0] part;
  } s2_t;

  typedef struct packed {
    logic init;
    q16_t init_val;
    logic keep;
    logic drop;
    q16_t elev;
    q16_t fill;
    q16_t best;
  } s3_t;

  function automatic q16_t min2(input q16_t a, input q16_t b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dpf_sum_stage.sv
`default_nettype none
module dpf_sum_stage
  import dpf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  input  wire q16_t              in_elev,
  input  wire q16_t              in_fill,
  input  wire q16_t [NB_CNT-1:0] in_nb,
  input  wire cfg_t              cfg,
  output logic                   s1_valid_r,
  output s1_t                    s1_r
);

  s1_t                s1_nxt;
  logic [NB_CNT-1:0]  nb_nd;
  logic [Q_W:0]       wide [NB_CNT];
  logic [GAP_W-1:0]   gap  [NB_CNT];

  always_comb begin
    for (int k = 0; k < NB_CNT; k++) begin
      gap[k]   = DIAG_MASK[k] ? cfg.gap_diag : cfg.gap_card;
      wide[k]  = {in_nb[k][Q_W-1], in_nb[k]} + {{(Q_W+1-GAP_W){1'b0}}, gap[k]};
      nb_nd[k] = (in_nb[k] == cfg.nodata);
      // saturate at the positive limit
      s1_nxt.sum[k] = (wide[k][Q_W:Q_W-1] == 2'b01) ? q16_t'(Q_MAX) : q16_t'(wide[k][Q_W-1:0]);
    end
    s1_nxt.init      = (in_cmd == CMD_INIT);
    s1_nxt.init_val  = (in_elev == cfg.nodata) ? cfg.nodata : cfg.fill_start;
    s1_nxt.keep      = (in_elev == cfg.nodata) || (in_fill <= in_elev);
    s1_nxt.nb_nodata = |nb_nd;
    s1_nxt.elev      = in_elev;
    s1_nxt.fill      = in_fill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/dpf_min_tree.sv
`default_nettype none
module dpf_min_tree
  import dpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s1_valid,
  input  wire s1_t  s1,
  output logic      s3_valid_r,
  output s3_t       s3_r
);

  logic              s2_valid_r;
  s2_t               s2_r;
  s2_t               s2_nxt;
  s3_t               s3_nxt;
  logic [NB_CNT-1:0] low;

  always_comb begin
    for (int k = 0; k < NB_CNT; k++) begin
      low[k] = (s1.sum[k] <= s1.elev);
    end
    for (int k = 0; k < NB_CNT/2; k++) begin
      s2_nxt.part[k] = min2(s1.sum[2*k], s1.sum[2*k+1]);
    end
    s2_nxt.init     = s1.init;
    s2_nxt.init_val = s1.init_val;
    s2_nxt.keep     = s1.keep;
    s2_nxt.drop     = s1.nb_nodata || (|low);
    s2_nxt.elev     = s1.elev;
    s2_nxt.fill     = s1.fill;
  end

  always_comb begin
    s3_nxt.init     = s2_r.init;
    s3_nxt.init_val = s2_r.init_val;
    s3_nxt.keep     = s2_r.keep;
    s3_nxt.drop     = s2_r.drop;
    s3_nxt.elev     = s2_r.elev;
    s3_nxt.fill     = s2_r.fill;
    s3_nxt.best     = min2(s2_r.fill, min2(min2(s2_r.part[0], s2_r.part[1]),
                                            min2(s2_r.part[2], s2_r.part[3])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/dem_pit_fill_cell_update.sv
// channel   | handshake                 | payload
// in        | start, busy               | in_command, in_center_*, in_fill_*
// out       | out_valid (one cycle)     | out_new_fill, out_changed
// cfg       | cfg_we                    | cfg_index, cfg_wdata
//
// one beat accepted per cycle unless busy; it passes the s1, s2, s3 and out_* registers
// pipeline of add, compare and min-tree stages (sum, 8->4, 4->1, select)
// synchronous active-low reset clears valid bits and loads register defaults
// busy is high during reset and in the first cycle after it; the receiver cannot stall
`default_nettype none
module dem_pit_fill_cell_update
  import dpf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic signed [31:0] in_center_elevation,
  input  wire logic signed [31:0] in_center_fill,
  input  wire logic signed [31:0] in_fill_nw,
  input  wire logic signed [31:0] in_fill_n,
  input  wire logic signed [31:0] in_fill_ne,
  input  wire logic signed [31:0] in_fill_w,
  input  wire logic signed [31:0] in_fill_e,
  input  wire logic signed [31:0] in_fill_sw,
  input  wire logic signed [31:0] in_fill_s,
  input  wire logic signed [31:0] in_fill_se,
  output logic                    out_valid,
  output logic signed [31:0]      out_new_fill,
  output logic                    out_changed,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  cfg_t              cfg_r;
  logic              busy_r;
  logic              in_acc;
  q16_t [NB_CNT-1:0] nb;
  logic              s1_valid;
  s1_t               s1;
  logic              s3_valid;
  s3_t               s3;
  q16_t              res_nxt;
  logic              chg_nxt;
  logic              out_valid_r;
  q16_t              out_fill_r;
  logic              out_chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nodata     <= q16_t'(NODATA_RST);
      cfg_r.fill_start <= q16_t'(FILL_START_RST);
      cfg_r.gap_card   <= GAP_CARD_RST;
      cfg_r.gap_diag   <= GAP_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODATA:     cfg_r.nodata     <= q16_t'(cfg_wdata);
        REG_FILL_START: cfg_r.fill_start <= q16_t'(cfg_wdata);
        REG_GAP_CARD:   cfg_r.gap_card   <= cfg_wdata[GAP_W-1:0];
        REG_GAP_DIAG:   cfg_r.gap_diag   <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  assign nb[0] = in_fill_nw;
  assign nb[1] = in_fill_n;
  assign nb[2] = in_fill_ne;
  assign nb[3] = in_fill_w;
  assign nb[4] = in_fill_e;
  assign nb[5] = in_fill_sw;
  assign nb[6] = in_fill_s;
  assign nb[7] = in_fill_se;

  dpf_sum_stage u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_acc),
    .in_cmd     (in_command),
    .in_elev    (in_center_elevation),
    .in_fill    (in_center_fill),
    .in_nb      (nb),
    .cfg        (cfg_r),
    .s1_valid_r (s1_valid),
    .s1_r       (s1)
  );

  dpf_min_tree u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s3_valid_r (s3_valid),
    .s3_r       (s3)
  );

  always_comb begin
    if (s3.init) begin
      res_nxt = s3.init_val;
      chg_nxt = 1'b1;
    end else if (s3.keep) begin
      res_nxt = s3.fill;
      chg_nxt = 1'b0;
    end else begin
      res_nxt = s3.drop ? s3.elev : s3.best;
      chg_nxt = (res_nxt != s3.fill);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_fill_r <= res_nxt;
    out_chg_r  <= chg_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_new_fill = out_fill_r;
  assign out_changed  = out_chg_r;

  a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 4))
    else $error("result beat without an accepted beat four cycles back");

  a_init_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_command == CMD_INIT, 4)) |-> out_changed)
    else $error("init beat returned with changed low");

  a_keep_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_changed) |-> (out_new_fill == $past(in_center_fill, 4)))
    else $error("unchanged result differs from center fill");

endmodule
`default_nettype wire
